@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the checker file
// each macro expects clk and rst_n in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/hrc_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and text tables of the http response parser
// no dependencies
package hrc_pkg;

    localparam int COOKIE_MAX = 64;
    localparam int INDEX_BITS = 32;
    localparam int STATUS_LEN = 15;
    localparam int PREFIX_LEN = 12;
    localparam int CK_ERR     = PREFIX_LEN + COOKIE_MAX;
    localparam int CK_DONE    = CK_ERR + 1;
    localparam int CK_W       = $clog2(CK_DONE + 1);
    localparam int PFX_IW     = $clog2(PREFIX_LEN);
    localparam int LEN_W      = $clog2(STATUS_LEN + 2);
    localparam int POS_W      = 6;
    localparam logic [7:0] MSG_ID_RESET = 8'd52;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_DATA  = 2'd1,
        OP_END   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        PH_STATUS     = 3'd0,
        PH_LINE_START = 3'd1,
        PH_LINE_CR    = 3'd2,
        PH_HEADER     = 3'd3,
        PH_BODY       = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        BD_ID    = 3'd0,
        BD_COMMA = 3'd1,
        BD_MSG   = 3'd2,
        BD_SKIP  = 3'd3,
        BD_INDEX = 3'd4,
        BD_DONE  = 3'd5,
        BD_ERR   = 3'd6
    } body_t;

    // classified input word
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
        logic       is_cr;
        logic       is_lf;
        logic       is_comma;
        logic       is_digit;
        logic [3:0] digit;
    } hrc_item_t;

    typedef struct packed {
        logic             msg_valid;
        logic [7:0]       msg_byte;
        logic             msg_end;
        logic             cookie_write;
        logic [POS_W-1:0] cookie_pos;
        logic [7:0]       cookie_byte;
        logic             verdict_valid;
        logic             status_ok;
        logic             body_done;
        logic [31:0]      index_value;
        logic             index_saturated;
    } hrc_result_t;

    function automatic logic [7:0] status_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "H";
            4'd1:    c = "T";
            4'd2:    c = "T";
            4'd3:    c = "P";
            4'd4:    c = "/";
            4'd5:    c = "1";
            4'd6:    c = ".";
            4'd7:    c = "1";
            4'd8:    c = " ";
            4'd9:    c = "2";
            4'd10:   c = "0";
            4'd11:   c = "0";
            4'd12:   c = " ";
            4'd13:   c = "O";
            4'd14:   c = "K";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] prefix_char(input logic [PFX_IW-1:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "S";
            4'd1:    c = "e";
            4'd2:    c = "t";
            4'd3:    c = "-";
            4'd4:    c = "C";
            4'd5:    c = "o";
            4'd6:    c = "o";
            4'd7:    c = "k";
            4'd8:    c = "i";
            4'd9:    c = "e";
            4'd10:   c = ":";
            4'd11:   c = " ";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ hw/rtl/hrc_if.sv @@
`timescale 1ns / 1ps
// valid/ready channel interfaces: request, result and configuration
// depends on hrc_pkg
interface hrc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;

    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface hrc_rsp_if
    import hrc_pkg::*;
    ;
    logic             valid;
    logic             ready;
    logic             msg_valid;
    logic [7:0]       msg_byte;
    logic             msg_end;
    logic             cookie_write;
    logic [POS_W-1:0] cookie_pos;
    logic [7:0]       cookie_byte;
    logic             verdict_valid;
    logic             status_ok;
    logic             body_done;
    logic [31:0]      index_value;
    logic             index_saturated;

    modport source (
        output valid, output msg_valid, output msg_byte, output msg_end,
        output cookie_write, output cookie_pos, output cookie_byte,
        output verdict_valid, output status_ok, output body_done,
        output index_value, output index_saturated, input ready
    );
    modport sink (
        input valid, input msg_valid, input msg_byte, input msg_end,
        input cookie_write, input cookie_pos, input cookie_byte,
        input verdict_valid, input status_ok, input body_done,
        input index_value, input index_saturated, output ready
    );
endinterface

interface hrc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_id;

    modport source (output valid, output msg_id, input ready);
    modport sink (input valid, input msg_id, output ready);
endinterface

@@ hw/rtl/hrc_fifo.sv @@
`timescale 1ns / 1ps
// two-entry queue of classified words between front and back
// depends on hrc_pkg
module hrc_fifo
    import hrc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  hrc_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output hrc_item_t pop_item
);

    hrc_item_t  mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hw/rtl/hrc_front.sv @@
`timescale 1ns / 1ps
// request side: accepts words and classifies the byte
// depends on hrc_pkg, hrc_if
module hrc_front
    import hrc_pkg::*;
(
    hrc_req_if.sink   req,
    input  logic      full,
    output logic      push,
    output hrc_item_t item
);

    assign req.ready = !full;
    assign push      = req.valid && !full;

    always_comb
    begin
        item.opcode    = req.opcode;
        item.data_byte = req.data_byte;
        item.is_cr     = (req.data_byte == CH_CR);
        item.is_lf     = (req.data_byte == CH_LF);
        item.is_comma  = (req.data_byte == CH_COMMA);
        item.is_digit  = (req.data_byte >= CH_ZERO) && (req.data_byte <= CH_NINE);
        item.digit     = 4'(req.data_byte - CH_ZERO);
    end

endmodule

@@ hw/rtl/hrc_back.sv @@
`timescale 1ns / 1ps
// execution side: parse state update, configuration register, result register
// depends on hrc_pkg, hrc_if
module hrc_back
    import hrc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  hrc_item_t q_item,
    output logic      pop,
    hrc_cfg_if.sink   cfg,
    hrc_rsp_if.source rsp
);

    logic [7:0]            msg_id_reg;
    phase_t                phase_reg;
    phase_t                phase_next;
    logic [LEN_W-1:0]      len_reg;
    logic [LEN_W-1:0]      len_next;
    logic                  match_reg;
    logic                  match_next;
    logic [CK_W-1:0]       ck_reg;
    logic [CK_W-1:0]       ck_next;
    body_t                 body_reg;
    body_t                 body_next;
    logic [INDEX_BITS-1:0] acc_reg;
    logic [INDEX_BITS-1:0] acc_next;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    hrc_result_t           res_reg;
    hrc_result_t           res_next;
    logic [INDEX_BITS+3:0] prod;
    logic [7:0]            ch;
    logic                  eoln;
    logic                  hdr;

    assign cfg.ready = 1'b1;
    assign pop       = q_valid && (!out_valid_reg || rsp.ready);
    assign ch        = q_item.data_byte;
    assign eoln      = q_item.is_cr || q_item.is_lf;
    // times ten plus digit
    assign prod = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1)
                + (INDEX_BITS + 4)'(q_item.digit);

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        match_next = match_reg;
        ck_next    = ck_reg;
        body_next  = body_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        res_next   = '0;
        hdr        = 1'b0;
        case (q_item.opcode)
            OP_START:
            begin
                phase_next = PH_STATUS;
                len_next   = '0;
                match_next = 1'b1;
                ck_next    = '0;
                body_next  = BD_ID;
                acc_next   = '0;
                ovf_next   = 1'b0;
            end
            OP_DATA:
            begin
                case (phase_reg)
                    PH_STATUS:
                    begin
                        if (q_item.is_lf)
                        begin
                            phase_next = PH_LINE_START;
                        end
                        else if (!q_item.is_cr)
                        begin
                            if (len_reg >= LEN_W'(STATUS_LEN)
                                || status_char(len_reg[3:0]) != ch)
                            begin
                                match_next = 1'b0;
                            end
                            if (len_reg < LEN_W'(STATUS_LEN + 1))
                            begin
                                len_next = len_reg + 1'b1;
                            end
                        end
                    end
                    PH_LINE_START:
                    begin
                        hdr = 1'b1;
                        if (q_item.is_cr)
                        begin
                            phase_next = PH_LINE_CR;
                        end
                        else if (q_item.is_lf)
                        begin
                            phase_next = PH_BODY;
                        end
                        else
                        begin
                            phase_next = PH_HEADER;
                        end
                    end
                    PH_LINE_CR:
                    begin
                        hdr        = 1'b1;
                        phase_next = q_item.is_lf ? PH_BODY : PH_LINE_START;
                    end
                    PH_HEADER:
                    begin
                        hdr = 1'b1;
                        if (q_item.is_lf)
                        begin
                            phase_next = PH_LINE_START;
                        end
                    end
                    default:
                    begin
                        case (body_reg)
                            BD_ID:
                            begin
                                body_next = (ch == msg_id_reg) ? BD_COMMA : BD_ERR;
                            end
                            BD_COMMA:
                            begin
                                body_next = q_item.is_comma ? BD_MSG : BD_ERR;
                            end
                            BD_MSG:
                            begin
                                if (q_item.is_comma)
                                begin
                                    res_next.msg_end = 1'b1;
                                    body_next        = BD_SKIP;
                                end
                                else
                                begin
                                    res_next.msg_valid = 1'b1;
                                    res_next.msg_byte  = ch;
                                end
                            end
                            BD_SKIP:
                            begin
                                if (q_item.is_comma)
                                begin
                                    body_next = BD_INDEX;
                                    acc_next  = '0;
                                    ovf_next  = 1'b0;
                                end
                            end
                            BD_INDEX:
                            begin
                                if (eoln)
                                begin
                                    body_next = BD_DONE;
                                end
                                else if (q_item.is_digit)
                                begin
                                    if (prod[INDEX_BITS+3:INDEX_BITS] != 4'd0)
                                    begin
                                        acc_next = '1;
                                        ovf_next = 1'b1;
                                    end
                                    else
                                    begin
                                        acc_next = prod[INDEX_BITS-1:0];
                                    end
                                end
                                else
                                begin
                                    body_next = BD_ERR;
                                end
                            end
                            default:
                            begin
                                body_next = body_reg;
                            end
                        endcase
                    end
                endcase
                if (hdr)
                begin
                    if (ck_reg < CK_W'(PREFIX_LEN))
                    begin
                        if (eoln)
                        begin
                            ck_next = '0;
                        end
                        else if (ch == prefix_char(ck_reg[PFX_IW-1:0]))
                        begin
                            ck_next = ck_reg + 1'b1;
                        end
                        else
                        begin
                            ck_next = CK_W'(CK_ERR);
                        end
                    end
                    else if (ck_reg < CK_W'(CK_ERR))
                    begin
                        if (eoln)
                        begin
                            ck_next = CK_W'(CK_DONE);
                        end
                        else
                        begin
                            res_next.cookie_write = 1'b1;
                            res_next.cookie_pos   = POS_W'(ck_reg - CK_W'(PREFIX_LEN));
                            res_next.cookie_byte  = ch;
                            ck_next               = ck_reg + 1'b1;
                        end
                    end
                    else if (ck_reg == CK_W'(CK_ERR))
                    begin
                        if (eoln)
                        begin
                            ck_next = '0;
                        end
                    end
                end
            end
            OP_END:
            begin
                res_next.verdict_valid   = 1'b1;
                res_next.status_ok       = (phase_reg != PH_STATUS) && match_reg
                                           && (len_reg == LEN_W'(STATUS_LEN));
                res_next.body_done       = (body_reg == BD_DONE);
                res_next.index_value     = 32'(acc_reg);
                res_next.index_saturated = ovf_reg;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_comb
    begin
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_id_reg    <= MSG_ID_RESET;
            phase_reg     <= PH_STATUS;
            len_reg       <= '0;
            match_reg     <= 1'b1;
            ck_reg        <= '0;
            body_reg      <= BD_ID;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                msg_id_reg <= cfg.msg_id;
            end
            if (pop)
            begin
                phase_reg <= phase_next;
                len_reg   <= len_next;
                match_reg <= match_next;
                ck_reg    <= ck_next;
                body_reg  <= body_next;
                acc_reg   <= acc_next;
                ovf_reg   <= ovf_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.msg_valid       = res_reg.msg_valid;
    assign rsp.msg_byte        = res_reg.msg_byte;
    assign rsp.msg_end         = res_reg.msg_end;
    assign rsp.cookie_write    = res_reg.cookie_write;
    assign rsp.cookie_pos      = res_reg.cookie_pos;
    assign rsp.cookie_byte     = res_reg.cookie_byte;
    assign rsp.verdict_valid   = res_reg.verdict_valid;
    assign rsp.status_ok       = res_reg.status_ok;
    assign rsp.body_done       = res_reg.body_done;
    assign rsp.index_value     = res_reg.index_value;
    assign rsp.index_saturated = res_reg.index_saturated;

endmodule

@@ hw/rtl/http_response_cookie_body_parser_top.sv @@
`timescale 1ns / 1ps
// HTTP response parser: one request word (start, data byte or end) gives one
// result word. Sustained rate is one word per clock while results are taken; a
// result is registered as its request leaves the queue. The rate is set by the
// parse state update in the back end, whose widest path is the index multiply
// by ten with overflow check. A two-word queue lets the request side keep
// accepting while a result waits, until it is full. msg_id may be written only while
// no word is in flight; no clearing pass runs after reset.
module http_response_cookie_body_parser_top
    import hrc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    hrc_req_if.sink   req,
    hrc_cfg_if.sink   cfg,
    hrc_rsp_if.source rsp
);

    hrc_item_t front_item;
    hrc_item_t q_item;
    logic      push;
    logic      full;
    logic      pop;
    logic      q_valid;

    hrc_front u_front (
        .req  (req),
        .full (full),
        .push (push),
        .item (front_item)
    );

    hrc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (full),
        .pop       (pop),
        .not_empty (q_valid),
        .pop_item  (q_item)
    );

    hrc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .pop     (pop),
        .cfg     (cfg),
        .rsp     (rsp)
    );

endmodule

@@ hw/rtl/hrc_checker.sv @@
`timescale 1ns / 1ps
// port-level checks of the result channel, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module hrc_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        msg_valid,
    input logic        msg_end,
    input logic        cookie_write,
    input logic        verdict_valid,
    input logic        status_ok,
    input logic        body_done,
    input logic [31:0] index_value,
    input logic        index_saturated
);

    `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
        rsp_valid && $stable(index_value), "result word dropped or changed while stalled")
    `ASSERT_IMPL(a_verdict_alone, rsp_valid && verdict_valid,
        !msg_valid && !msg_end && !cookie_write, "verdict word carries data")
    `ASSERT_IMPL(a_no_verdict_zero, rsp_valid && !verdict_valid,
        !status_ok && !body_done && index_value == 32'd0 && !index_saturated,
        "verdict fields set on data word")
    `ASSERT_IMPL(a_sat_max, rsp_valid && index_saturated,
        index_value == 32'hffff_ffff, "saturated index not at maximum")

endmodule

bind http_response_cookie_body_parser_top hrc_port_checker u_hrc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .msg_valid       (rsp.msg_valid),
    .msg_end         (rsp.msg_end),
    .cookie_write    (rsp.cookie_write),
    .verdict_valid   (rsp.verdict_valid),
    .status_ok       (rsp.status_ok),
    .body_done       (rsp.body_done),
    .index_value     (rsp.index_value),
    .index_saturated (rsp.index_saturated)
);
